@@ hw/rtl/vpsr_pkg.sv @@
`timescale 1ns / 1ps

package vpsr_pkg;

    // Default geometry of the video stream
    localparam int PACKETS_PER_SEGMENT_DEF = 60;
    localparam int GROUPS_PER_PACKET_DEF   = 20;
    localparam int EARLY_PACKETS_DEF       = 20;
    localparam int SEGMENTS_DEF            = 4;
    localparam int QUEUE_DEPTH_DEF         = 4;

    localparam int GROUP_BYTES = 7;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 56;
    localparam int STATUS_W    = 2;
    localparam int SEG_W       = 4;

    // Capture status codes as seen on the result beat
    localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ARMED    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PROGRESS = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd3;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] word_value;
        logic              first_word;
    } item_t;

    typedef struct packed {
        logic                write_enable;
        logic [ADDR_W-1:0]   byte_address;
        logic [DATA_W-1:0]   group_data;
        logic [STATUS_W-1:0] capture_status;
        logic [SEG_W-1:0]    segment_number;
        logic                last;
    } result_t;

    // One classified word, as handed from the front to the back
    typedef struct packed {
        logic                replay;
        logic                write;
        logic [ADDR_W-1:0]   replay_addr;
        logic [DATA_W-1:0]   replay_data;
        logic [ADDR_W-1:0]   main_addr;
        logic [DATA_W-1:0]   main_data;
        logic [STATUS_W-1:0] status;
        logic [SEG_W-1:0]    segment;
    } cmd_t;

endpackage

@@ hw/rtl/vpsr_front.sv @@
`timescale 1ns / 1ps

module vpsr_front #(
    parameter int PACKETS_PER_SEGMENT = vpsr_pkg::PACKETS_PER_SEGMENT_DEF,
    parameter int GROUPS_PER_PACKET   = vpsr_pkg::GROUPS_PER_PACKET_DEF,
    parameter int EARLY_PACKETS       = vpsr_pkg::EARLY_PACKETS_DEF,
    parameter int SEGMENTS            = vpsr_pkg::SEGMENTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  vpsr_pkg::item_t item,
    output logic            push_valid,
    input  logic            queue_full,
    output vpsr_pkg::cmd_t  push_data
);
    import vpsr_pkg::*;

    localparam int WPOS_W      = $clog2(2 * GROUPS_PER_PACKET + 2);
    localparam int GRP_W       = (GROUPS_PER_PACKET > 1) ? $clog2(GROUPS_PER_PACKET) : 1;
    localparam int STORE_DEPTH = EARLY_PACKETS * GROUPS_PER_PACKET;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [WPOS_W-1:0] LAST_POS      = WPOS_W'(2 * GROUPS_PER_PACKET);
    localparam logic [ADDR_W-1:0] GROUP_BYTES_A = ADDR_W'(GROUP_BYTES);
    localparam logic [ADDR_W-1:0] PACKET_BYTES  = ADDR_W'(GROUPS_PER_PACKET * GROUP_BYTES);
    localparam logic [ADDR_W-1:0] SEGMENT_BYTES =
        ADDR_W'(PACKETS_PER_SEGMENT * GROUPS_PER_PACKET * GROUP_BYTES);
    localparam logic [ADDR_W-1:0] GROUPS_A      = ADDR_W'(GROUPS_PER_PACKET);
    localparam logic [7:0]        EARLY_PKT     = 8'(EARLY_PACKETS);
    localparam logic [7:0]        SEG_PKTS      = 8'(PACKETS_PER_SEGMENT);
    localparam logic [7:0]        LAST_PKT      = 8'(PACKETS_PER_SEGMENT - 1);
    localparam logic [SEG_W-1:0]  LAST_SEG      = SEG_W'(SEGMENTS);
    localparam logic [GRP_W-1:0]  LAST_GRP      = GRP_W'(GROUPS_PER_PACKET - 1);

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_ARMED    = 4'b0010,
        MODE_PROGRESS = 4'b0100,
        MODE_DONE     = 4'b1000
    } mode_t;

    function automatic logic [STATUS_W-1:0] mode_status(input mode_t m);
        logic [STATUS_W-1:0] s;
        unique case (m)
            MODE_IDLE:     s = STATUS_IDLE;
            MODE_ARMED:    s = STATUS_ARMED;
            MODE_PROGRESS: s = STATUS_PROGRESS;
            MODE_DONE:     s = STATUS_DONE;
            default:       s = STATUS_IDLE;
        endcase
        return s;
    endfunction

    logic [WPOS_W-1:0] wpos_reg, wpos_next;
    logic [7:0]        pkt_reg, pkt_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic              usable_reg, usable_next;
    logic [27:0]       held_reg, held_next;
    mode_t             mode_reg, mode_next;
    logic              s1_valid_reg, s1_valid_next;
    cmd_t              s1_cmd_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] store [STORE_DEPTH];

    logic              accept;
    logic              is_data;
    logic              group_sel;
    logic [27:0]       pair;
    logic [DATA_W-1:0] grp;
    logic [WPOS_W-1:0] half;
    logic [GRP_W-1:0]  grp_idx;
    logic              seg_ok;
    logic              pkt_ok;
    logic              frame;
    logic              write_main;
    logic              replay;
    logic              done;
    logic              store_wr;
    logic [7:0]        rp;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] wr_full;
    logic [ADDR_W-1:0] rd_full;
    logic [STORE_AW-1:0] wr_idx;
    logic [STORE_AW-1:0] rd_idx;
    cmd_t              cmd_next;

    assign item_stall = s1_valid_reg && queue_full;
    assign accept     = item_valid && !item_stall;
    assign push_valid = s1_valid_reg;

    // Classify the word against the current packet state
    always_comb
    begin
        is_data   = !item.action && !item.first_word && usable_reg &&
                    (wpos_reg != '0) && (wpos_reg <= LAST_POS);
        group_sel = is_data && !wpos_reg[0];
        pair      = {item.word_value[13:0], item.word_value[29:16]};
        grp       = {pair, held_reg};
        half      = wpos_reg >> 1;
        grp_idx   = GRP_W'(half - WPOS_W'(1));
        seg_ok    = (seg_reg != '0) && (seg_reg <= LAST_SEG);
        pkt_ok    = (pkt_reg >= EARLY_PKT) && (pkt_reg < SEG_PKTS);
        frame     = group_sel && seg_ok && pkt_ok;
        write_main = frame && (mode_reg == MODE_PROGRESS);
        rp        = pkt_reg - EARLY_PKT;
        replay    = write_main && (rp < EARLY_PKT);
        done      = frame && (pkt_reg == LAST_PKT) && (seg_reg == LAST_SEG) &&
                    (grp_idx == LAST_GRP);
        store_wr  = group_sel && !(seg_ok && pkt_ok) && (pkt_reg < EARLY_PKT);
        base      = (ADDR_W'(seg_reg) - ADDR_W'(1)) * SEGMENT_BYTES +
                    ADDR_W'(grp_idx) * GROUP_BYTES_A;
        wr_full   = ADDR_W'(pkt_reg) * GROUPS_A + ADDR_W'(grp_idx);
        rd_full   = ADDR_W'(rp) * GROUPS_A + ADDR_W'(grp_idx);
        wr_idx    = STORE_AW'(wr_full);
        rd_idx    = STORE_AW'(rd_full);
    end

    // Advance the packet and capture state
    always_comb
    begin
        wpos_next   = wpos_reg;
        pkt_next    = pkt_reg;
        seg_next    = seg_reg;
        usable_next = usable_reg;
        held_next   = held_reg;
        mode_next   = mode_reg;
        if (item.action)
        begin
            mode_next = MODE_ARMED;
        end
        else if (item.first_word)
        begin
            wpos_next = WPOS_W'(1);
            if (item.word_value[27:24] != 4'h0)
            begin
                usable_next = 1'b0;
            end
            else
            begin
                usable_next = 1'b1;
                pkt_next    = item.word_value[23:16];
                if (item.word_value[23:16] == EARLY_PKT)
                begin
                    seg_next = item.word_value[31:28];
                    if ((item.word_value[31:28] == SEG_W'(1)) && (mode_reg == MODE_ARMED))
                    begin
                        mode_next = MODE_PROGRESS;
                    end
                end
            end
        end
        else if (is_data)
        begin
            wpos_next = wpos_reg + WPOS_W'(1);
            if (wpos_reg[0])
            begin
                held_next = pair;
            end
            else if (done)
            begin
                mode_next = MODE_DONE;
            end
        end
    end

    always_comb
    begin
        cmd_next             = '0;
        cmd_next.replay      = replay;
        cmd_next.write       = write_main;
        cmd_next.replay_addr = base + ADDR_W'(rp) * PACKET_BYTES;
        cmd_next.main_addr   = write_main ? (base + ADDR_W'(pkt_reg) * PACKET_BYTES) : '0;
        cmd_next.main_data   = write_main ? grp : '0;
        cmd_next.status      = mode_status(mode_next);
        cmd_next.segment     = seg_next;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_valid_reg && !queue_full)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg     <= '0;
            pkt_reg      <= '0;
            seg_reg      <= '0;
            usable_reg   <= 1'b0;
            held_reg     <= '0;
            mode_reg     <= MODE_IDLE;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                wpos_reg   <= wpos_next;
                pkt_reg    <= pkt_next;
                seg_reg    <= seg_next;
                usable_reg <= usable_next;
                held_reg   <= held_next;
                mode_reg   <= mode_next;
            end
        end
    end

    // Early-packet store: at most one write or one registered read per word
    always_ff @(posedge clk)
    begin
        if (accept && store_wr)
        begin
            store[wr_idx] <= grp;
        end
        if (accept && replay)
        begin
            rd_data_reg <= store[rd_idx];
        end
        if (accept)
        begin
            s1_cmd_reg <= cmd_next;
        end
    end

    always_comb
    begin
        push_data             = s1_cmd_reg;
        push_data.replay_data = rd_data_reg;
    end

    a_store_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(store_wr && replay))
        else $error("early store written and replayed by one word");

    a_replay_with_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_cmd_reg.replay |-> s1_cmd_reg.write)
        else $error("replay queued without a frame write");

    a_held_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && queue_full |=> s1_valid_reg && $stable(s1_cmd_reg))
        else $error("staged command lost while the queue was full");

endmodule

@@ hw/rtl/vpsr_queue.sv @@
`timescale 1ns / 1ps

module vpsr_queue #(
    parameter int DEPTH = vpsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  vpsr_pkg::cmd_t push_data,
    output logic           full,
    output logic           head_valid,
    output vpsr_pkg::cmd_t head,
    input  logic           pop
);
    import vpsr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/vpsr_back.sv @@
`timescale 1ns / 1ps

module vpsr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  vpsr_pkg::cmd_t    head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output vpsr_pkg::result_t result
);
    import vpsr_pkg::*;

    logic    result_valid_reg;
    result_t result_reg;
    logic    phase_reg;
    logic    load_ok;
    logic    take_replay;
    result_t beat;

    assign load_ok      = !result_valid_reg || !result_stall;
    assign take_replay  = head.replay && !phase_reg;
    assign pop          = head_valid && load_ok && !take_replay;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Replay beat first, then the beat for the word itself
    always_comb
    begin
        beat.capture_status = head.status;
        beat.segment_number = head.segment;
        if (take_replay)
        begin
            beat.write_enable = 1'b1;
            beat.byte_address = head.replay_addr;
            beat.group_data   = head.replay_data;
            beat.last         = 1'b0;
        end
        else
        begin
            beat.write_enable = head.write;
            beat.byte_address = head.main_addr;
            beat.group_data   = head.main_data;
            beat.last         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            phase_reg        <= 1'b0;
        end
        else if (load_ok)
        begin
            result_valid_reg <= head_valid;
            if (head_valid)
            begin
                phase_reg <= take_replay;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && head_valid)
        begin
            result_reg <= beat;
        end
    end

    a_first_beat_writes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.last |-> result_reg.write_enable)
        else $error("non-final beat without a write");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_stall && !result_reg.last
        |=> result_valid_reg && result_reg.write_enable && result_reg.last)
        else $error("replay beat not followed by its frame write");

    a_idle_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.write_enable
        |-> (result_reg.byte_address == '0) && (result_reg.group_data == '0))
        else $error("beat without write carries address or data");

endmodule

@@ hw/rtl/video_packet_segment_reassembler.sv @@
`timescale 1ns / 1ps

// Channel   Handshake                    Payload    Beat
// item      item_valid / item_stall      item_t     one stream word or an arm action
// result    result_valid / result_stall  result_t   one frame write or one status beat
//
// One word is taken every cycle unless item_stall is high; a word that
// replays an early-packet group yields two result beats and all others
// one, so the output side sets the rate. A word passes through the front
// stage, the queue and the output register before its first result beat.
// Reset is asynchronous; the early-packet store has no clearing pass and
// needs none after reset. Either side may stall: the queue absorbs it.

module video_packet_segment_reassembler #(
    parameter int PACKETS_PER_SEGMENT = vpsr_pkg::PACKETS_PER_SEGMENT_DEF,
    parameter int GROUPS_PER_PACKET   = vpsr_pkg::GROUPS_PER_PACKET_DEF,
    parameter int EARLY_PACKETS       = vpsr_pkg::EARLY_PACKETS_DEF,
    parameter int SEGMENTS            = vpsr_pkg::SEGMENTS_DEF,
    parameter int QUEUE_DEPTH         = vpsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  vpsr_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output vpsr_pkg::result_t result
);
    import vpsr_pkg::*;

    // Front to queue: classified word with any replayed store group
    logic push_valid;
    cmd_t push_data;
    logic queue_full;

    // Queue to back
    logic head_valid;
    cmd_t head;
    logic pop;

    // Front: track packet, segment and capture state, keep the early
    // packets, and turn each word into one queued command
    vpsr_front #(
        .PACKETS_PER_SEGMENT (PACKETS_PER_SEGMENT),
        .GROUPS_PER_PACKET   (GROUPS_PER_PACKET),
        .EARLY_PACKETS       (EARLY_PACKETS),
        .SEGMENTS            (SEGMENTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push_valid (push_valid),
        .queue_full (queue_full),
        .push_data  (push_data)
    );

    // Queue: decouple the word stream from the result stream
    vpsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Back: expand each command into one or two result beats
    vpsr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
